// ===== rtl/quaternion_to_euler_defines.svh =====
// Assertion macros for the quaternion to Euler angle converter.
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

`ifndef SYNTH
`define QTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qte assertion failed");
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qte assertion failed");
`else
`define QTE_ASSERT_NOW(label, clk, rst, ante, cons)
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/qte_pkg.sv =====
// Types, widths and helper functions of the quaternion to Euler angle converter.
package qte_pkg;

   localparam int CompW     = 16;
   localparam int AngleW    = 16;
   localparam int WorkFrac  = ((CompW - 2) > 15) ? 15 : (CompW - 2);
   localparam int InDrop    = (CompW - 2) - WorkFrac;
   localparam int WorkW     = WorkFrac + 2;
   localparam int ProdW     = 2 * WorkW;
   localparam int NumW      = 2 * WorkW + 3;
   localparam int MagW      = 2 * WorkFrac + 1;
   localparam int RadW      = 4 * WorkFrac + 1;
   localparam int RootW     = 2 * WorkFrac + 1;
   localparam int IsqSteps  = 2 * WorkFrac + 1;
   localparam int ScaleLog  = 38 - 2 * WorkFrac;
   localparam int CordW     = NumW + ScaleLog + 3;
   localparam int RoundSh   = 32 - AngleW;

   localparam logic signed [NumW-1:0] One2 = NumW'(1) <<< (2 * WorkFrac);
   localparam logic [RadW:0] One4 = (RadW + 1)'(1) << (4 * WorkFrac);
   localparam logic [31:0] RoundHalf = (RoundSh > 0) ? (32'd1 << (RoundSh - 1)) : 32'd0;

   localparam logic [31:0] AngZero    = 32'h0000_0000;
   localparam logic [31:0] AngQuarter = 32'h4000_0000;
   localparam logic [31:0] AngHalf    = 32'h8000_0000;
   localparam logic [31:0] AngMinusQ  = 32'hC000_0000;

   typedef struct packed {
      logic signed [CompW-1:0] comp_w;
      logic signed [CompW-1:0] comp_x;
      logic signed [CompW-1:0] comp_y;
      logic signed [CompW-1:0] comp_z;
   } qte_req_type;

   typedef struct packed {
      logic signed [AngleW-1:0] roll_angle;
      logic signed [AngleW-1:0] pitch_angle;
      logic signed [AngleW-1:0] yaw_angle;
      logic                     pitch_clamped;
   } qte_rsp_type;

   typedef struct packed {
      logic signed [NumW-1:0] roll_num;
      logic signed [NumW-1:0] roll_den;
      logic signed [NumW-1:0] yaw_num;
      logic signed [NumW-1:0] yaw_den;
      logic signed [NumW-1:0] pitch_s;
      logic                   clamped;
   } qte_side_type;

   typedef struct packed {
      logic [RadW-1:0] rad;
      qte_side_type    side;
   } qte_front_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         5'd31: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic [AngleW-1:0] round_angle(input logic [31:0] ang);
      logic [31:0] r;
      r = (ang + RoundHalf) >> RoundSh;
      return r[AngleW-1:0];
   endfunction

endpackage

// ===== rtl/qte_front.sv =====
// Front stages: products, numerators and denominators, asin clamp, radicand.
module qte_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  qte_pkg::qte_req_type  in_data,
   output logic                  out_valid,
   output qte_pkg::qte_front_type out_data
);
   import qte_pkg::*;

   logic signed [WorkW-1:0] w, x, y, z;
   assign w = WorkW'(in_data.comp_w >>> InDrop);
   assign x = WorkW'(in_data.comp_x >>> InDrop);
   assign y = WorkW'(in_data.comp_y >>> InDrop);
   assign z = WorkW'(in_data.comp_z >>> InDrop);

   // stage 1: products
   logic signed [ProdW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;
   logic                    v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         wx_ff <= ProdW'(w) * ProdW'(x);
         yz_ff <= ProdW'(y) * ProdW'(z);
         xx_ff <= ProdW'(x) * ProdW'(x);
         yy_ff <= ProdW'(y) * ProdW'(y);
         wz_ff <= ProdW'(w) * ProdW'(z);
         xy_ff <= ProdW'(x) * ProdW'(y);
         zz_ff <= ProdW'(z) * ProdW'(z);
         wy_ff <= ProdW'(w) * ProdW'(y);
         zx_ff <= ProdW'(z) * ProdW'(x);
      end
   end

   // stage 2: combine and clamp
   logic signed [NumW-1:0] s_raw, s_in, mag_full;
   logic                   clamp_in;

   always_comb begin
      s_raw = (NumW'(wy_ff) - NumW'(zx_ff)) <<< 1;
      clamp_in = 1'b0;
      s_in = s_raw;
      if (s_raw > One2) begin
         s_in = One2;
         clamp_in = 1'b1;
      end else if (s_raw < -One2) begin
         s_in = -One2;
         clamp_in = 1'b1;
      end
      mag_full = s_in[NumW-1] ? -s_in : s_in;
   end

   qte_side_type side2_ff;
   logic [MagW-1:0] mag_ff;
   logic            v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         side2_ff.roll_num <= (NumW'(wx_ff) + NumW'(yz_ff)) <<< 1;
         side2_ff.roll_den <= One2 - ((NumW'(xx_ff) + NumW'(yy_ff)) <<< 1);
         side2_ff.yaw_num  <= (NumW'(wz_ff) + NumW'(xy_ff)) <<< 1;
         side2_ff.yaw_den  <= One2 - ((NumW'(yy_ff) + NumW'(zz_ff)) <<< 1);
         side2_ff.pitch_s  <= s_in;
         side2_ff.clamped  <= clamp_in;
         mag_ff            <= mag_full[MagW-1:0];
      end
   end

   // stage 3: radicand one^4 - s^2
   logic [RadW:0] sq;
   assign sq = (RadW + 1)'(mag_ff) * (RadW + 1)'(mag_ff);

   logic v3_ff;
   qte_front_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         out_ff.rad  <= RadW'(One4 - sq);
         out_ff.side <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

// ===== rtl/qte_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, side data alongside.
module qte_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  qte_pkg::qte_front_type in_data,
   output logic                  out_valid,
   output logic [qte_pkg::RootW-1:0] out_root,
   output qte_pkg::qte_side_type out_side
);
   import qte_pkg::*;

   logic [RadW-1:0] v_ff   [0:IsqSteps];
   logic [RadW:0]   res_ff [0:IsqSteps];
   qte_side_type    side_ff[0:IsqSteps];
   logic            vld_ff [0:IsqSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         v_ff[0]    <= in_data.rad;
         res_ff[0]  <= '0;
         side_ff[0] <= in_data.side;
      end
   end

   for (genvar j = 0; j < IsqSteps; j++) begin : g_step
      localparam logic [RadW:0] Bit = (RadW + 1)'(1) << (4 * WorkFrac - 2 * j);
      logic [RadW:0] sum;
      assign sum = res_ff[j] + Bit;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            vld_ff[j+1] <= vld_ff[j];
         end
         if (en) begin
            side_ff[j+1] <= side_ff[j];
            if ({1'b0, v_ff[j]} >= sum) begin
               v_ff[j+1]   <= v_ff[j] - sum[RadW-1:0];
               res_ff[j+1] <= (res_ff[j] >> 1) + Bit;
            end else begin
               v_ff[j+1]   <= v_ff[j];
               res_ff[j+1] <= res_ff[j] >> 1;
            end
         end
      end
   end

   assign out_valid = vld_ff[IsqSteps];
   assign out_root  = res_ff[IsqSteps][RootW-1:0];
   assign out_side  = side_ff[IsqSteps];

endmodule

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with axis special cases, 32-bit binary angle.
module qte_cordic #(
   parameter int STEPS = 16
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [qte_pkg::NumW-1:0]  y_in,
   input  logic signed [qte_pkg::NumW-1:0]  x_in,
   output logic [31:0]                      ang_out
);
   import qte_pkg::*;

   logic signed [CordW-1:0] cx_ff [0:STEPS];
   logic signed [CordW-1:0] cy_ff [0:STEPS];
   logic [31:0]             ang_ff[0:STEPS];
   logic                    sp_ff [0:STEPS];
   logic [31:0]             spa_ff[0:STEPS];

   logic signed [CordW-1:0] cx0, cy0;
   logic [31:0]             sp_ang;
   logic                    sp_hit;

   assign cx0 = CordW'(x_in) <<< ScaleLog;
   assign cy0 = CordW'(y_in) <<< ScaleLog;

   always_comb begin
      sp_hit = 1'b1;
      if (x_in == '0 && y_in == '0) begin
         sp_ang = AngZero;
      end else if (x_in == '0) begin
         sp_ang = y_in[NumW-1] ? AngMinusQ : AngQuarter;
      end else if (y_in == '0) begin
         sp_ang = x_in[NumW-1] ? AngHalf : AngZero;
      end else begin
         sp_ang = AngZero;
         sp_hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp_ff[0]  <= sp_hit;
         spa_ff[0] <= sp_ang;
         if (x_in[NumW-1]) begin
            cx_ff[0]  <= -cx0;
            cy_ff[0]  <= -cy0;
            ang_ff[0] <= AngHalf;
         end else begin
            cx_ff[0]  <= cx0;
            cy_ff[0]  <= cy0;
            ang_ff[0] <= AngZero;
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      localparam logic [31:0] Atan = atan_entry(5'(k));
      logic signed [CordW-1:0] dx, dy;
      assign dx = cy_ff[k] >>> k;
      assign dy = cx_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (en) begin
            sp_ff[k+1]  <= sp_ff[k];
            spa_ff[k+1] <= spa_ff[k];
            if (!cy_ff[k][CordW-1]) begin
               cx_ff[k+1]  <= cx_ff[k] + dx;
               cy_ff[k+1]  <= cy_ff[k] - dy;
               ang_ff[k+1] <= ang_ff[k] + Atan;
            end else begin
               cx_ff[k+1]  <= cx_ff[k] - dx;
               cy_ff[k+1]  <= cy_ff[k] + dy;
               ang_ff[k+1] <= ang_ff[k] - Atan;
            end
         end
      end
   end

   assign ang_out = sp_ff[STEPS] ? spa_ff[STEPS] : ang_ff[STEPS];

endmodule

// ===== rtl/quaternion_to_euler.sv =====
// Top level: quaternion in, roll / pitch / yaw binary angles out.
//
//   port group  dir  payload          transfer when
//   req_        in   qte_req_type     req_valid && req_ready
//   rsp_        out  qte_rsp_type     rsp_valid && rsp_ready
//
// One quaternion per cycle while the output is not stalled; the pipeline runs through
// the front stages, the one-bit-per-stage square root, the CORDIC stages and the output register.
// Reset clears the valid bits only.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
`include "quaternion_to_euler_defines.svh"
module quaternion_to_euler #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qte_pkg::qte_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qte_pkg::qte_rsp_type rsp_data
);
   import qte_pkg::*;

   localparam logic signed [AngleW-1:0] PitchMax = AngleW'(1) <<< (AngleW - 2);

   logic en;
   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;

   logic          f_valid;
   qte_front_type f_data;

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   logic             i_valid;
   logic [RootW-1:0] i_root;
   qte_side_type     i_side;

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (i_valid),
      .out_root  (i_root),
      .out_side  (i_side)
   );

   logic signed [NumW-1:0] pitch_x;
   assign pitch_x = $signed({{(NumW - RootW){1'b0}}, i_root});

   logic [31:0] roll_ang, pitch_ang, yaw_ang;

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock), .en (en),
      .y_in (i_side.roll_num), .x_in (i_side.roll_den), .ang_out (roll_ang)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock), .en (en),
      .y_in (i_side.pitch_s), .x_in (pitch_x), .ang_out (pitch_ang)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock), .en (en),
      .y_in (i_side.yaw_num), .x_in (i_side.yaw_den), .ang_out (yaw_ang)
   );

   logic cvalid_ff [0:CORDIC_STEPS];
   logic clamp_ff  [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff[0] <= 1'b0;
      end else if (en) begin
         cvalid_ff[0] <= i_valid;
      end
      if (en) begin
         clamp_ff[0] <= i_side.clamped;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            cvalid_ff[k+1] <= 1'b0;
         end else if (en) begin
            cvalid_ff[k+1] <= cvalid_ff[k];
         end
         if (en) begin
            clamp_ff[k+1] <= clamp_ff[k];
         end
      end
   end

   logic [31:0] pitch_lim;
   always_comb begin
      pitch_lim = pitch_ang;
      if (pitch_ang > AngQuarter && pitch_ang < AngHalf) begin
         pitch_lim = AngQuarter;
      end else if (pitch_ang >= AngHalf && pitch_ang < AngMinusQ) begin
         pitch_lim = AngMinusQ;
      end
   end

   logic        out_valid_ff;
   qte_rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= cvalid_ff[CORDIC_STEPS];
      end
      if (en) begin
         out_ff.roll_angle    <= round_angle(roll_ang);
         out_ff.pitch_angle   <= round_angle(pitch_lim);
         out_ff.yaw_angle     <= round_angle(yaw_ang);
         out_ff.pitch_clamped <= clamp_ff[CORDIC_STEPS];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `QTE_ASSERT_NOW(a_clamp_pitch, clock, reset, rsp_valid && rsp_data.pitch_clamped, rsp_data.pitch_angle == PitchMax || rsp_data.pitch_angle == -PitchMax)
   `QTE_ASSERT_NOW(a_pitch_range, clock, reset, rsp_valid, rsp_data.pitch_angle <= PitchMax && rsp_data.pitch_angle >= -PitchMax)
   `QTE_ASSERT_NEXT(a_stall_hold, clock, reset, !req_ready, rsp_valid)

endmodule
